>>> hw/rtl/nwk_pkg.sv
// Shared types, codes and character tables of the Newick token validator.
`timescale 1ns / 1ps
`default_nettype none

package nwk_pkg;

    // Token kinds as they appear on the result port
    typedef enum logic [3:0] {
        K_NONE  = 4'd0,
        K_ATTR  = 4'd1,
        K_OPEN  = 4'd2,
        K_CLOSE = 4'd3,
        K_COMMA = 4'd4,
        K_COLON = 4'd5,
        K_SEMI  = 4'd6,
        K_HASH  = 4'd7,
        K_LABEL = 4'd8
    } t_kind;

    // Error codes, first one in stream order wins
    typedef enum logic [3:0] {
        E_OK        = 4'd0,
        E_BLANK     = 4'd1,
        E_ILLEGAL   = 4'd2,
        E_UNCLOSED  = 4'd3,
        E_BAD_FIRST = 4'd4,
        E_STRAY     = 4'd5,
        E_SECOND    = 4'd6,
        E_EXTRA     = 4'd7,
        E_ORDER     = 4'd8,
        E_COUNT     = 4'd9,
        E_OVERFLOW  = 4'd10
    } t_err;

    // Lexer modes
    typedef enum logic [1:0] {
        M_BETWEEN = 2'd0,
        M_ATTR    = 2'd1,
        M_LABEL   = 2'd2
    } t_mode;

    localparam int COUNT_OUT_W = 13;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [3:0]             token_kind;
        logic                   token_begins;
        logic [3:0]             error_code;
        logic                   text_done;
        logic [COUNT_OUT_W-1:0] tips_seen;
        logic [COUNT_OUT_W-1:0] inner_seen;
    } t_result;

    // Classified byte handed from the lexer to the checker
    typedef struct packed {
        t_kind kind;
        logic  begins;
        logic  bad_attr;
        logic  illegal;
        logic  comment_start;
        logic  attr_open;
        logic  last;
    } t_token;

    function automatic logic is_label_char(logic [7:0] b);
        return (b == 8'h21) || (b == 8'h5C) ||
               (b >= 8'h23 && b <= 8'h26) ||
               (b == 8'h2A) || (b == 8'h2B) ||
               (b >= 8'h2D && b <= 8'h39) ||
               (b >= 8'h3C && b <= 8'h5A) ||
               (b >= 8'h5E && b <= 8'h7E);
    endfunction

    function automatic logic is_attr_char(logic [7:0] b);
        return (b >= 8'h20) && (b <= 8'h7E) && (b != CH_LBRACK) && (b != CH_RBRACK);
    endfunction

    // Allowed successor table: row is the prior token, bit is the new token
    function automatic logic follow_ok(t_kind prior, t_kind kind);
        logic [8:0] row;
        unique case (prior)
            K_NONE:  row = 9'b1_0000_0100;
            K_ATTR:  row = 9'b0_1111_1000;
            K_OPEN:  row = 9'b1_0000_0100;
            K_CLOSE: row = 9'b1_1111_1010;
            K_COMMA: row = 9'b1_0000_0100;
            K_COLON: row = 9'b1_0000_0000;
            K_SEMI:  row = 9'b0_0000_0000;
            K_HASH:  row = 9'b1_0000_0000;
            K_LABEL: row = 9'b0_1111_1010;
            default: row = 9'b0_0000_0000;
        endcase
        return (kind <= K_LABEL) ? row[kind] : 1'b0;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nwk_lexer.sv
// Front end: byte classifier and lexer mode register.
`timescale 1ns / 1ps
`default_nettype none

module nwk_lexer import nwk_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_item  i_item,
    input  wire logic   i_take,
    output t_token      o_token
);

    t_mode r_mode;
    t_mode n_mode;

    always_comb begin
        logic [7:0] b;
        logic       done;
        logic       ws;
        t_mode      mode;
        t_kind      kind;
        logic       begins;
        logic       bad_attr;
        logic       illegal;

        b        = i_item.text_byte;
        done     = 1'b0;
        mode     = r_mode;
        kind     = K_NONE;
        begins   = 1'b0;
        bad_attr = 1'b0;
        illegal  = 1'b0;
        ws       = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);

        unique case (r_mode)
            M_LABEL: begin
                if (is_label_char(b)) begin
                    kind = K_LABEL;
                    done = 1'b1;
                end else begin
                    // byte ends the label, lex it as between tokens
                    mode = M_BETWEEN;
                end
            end
            M_ATTR: begin
                done = 1'b1;
                if (b == CH_RBRACK) begin
                    kind = K_ATTR;
                    mode = M_BETWEEN;
                end else if (is_attr_char(b)) begin
                    kind = K_ATTR;
                end else begin
                    bad_attr = 1'b1;
                    mode     = M_BETWEEN;
                end
            end
            default: begin
            end
        endcase

        if (!done && !ws) begin
            priority case (b)
                CH_OPEN:   kind = K_OPEN;
                CH_CLOSE:  kind = K_CLOSE;
                CH_LBRACK: begin
                    kind = K_ATTR;
                    mode = M_ATTR;
                end
                CH_COLON:  kind = K_COLON;
                CH_SEMI:   kind = K_SEMI;
                CH_COMMA:  kind = K_COMMA;
                CH_HASH:   kind = K_HASH;
                default: begin
                    if (is_label_char(b)) begin
                        kind = K_LABEL;
                        mode = M_LABEL;
                    end else begin
                        illegal = 1'b1;
                    end
                end
            endcase
            begins = (kind != K_NONE);
        end

        o_token.kind          = kind;
        o_token.begins        = begins;
        o_token.bad_attr      = bad_attr;
        o_token.illegal       = illegal;
        o_token.comment_start = begins && ((b == CH_HASH) || (b == CH_STAR));
        o_token.attr_open     = (mode == M_ATTR);
        o_token.last          = i_item.last_byte;

        // a new text starts after the last byte
        n_mode = i_item.last_byte ? M_BETWEEN : mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_BETWEEN;
        end else if (i_take) begin
            r_mode <= n_mode;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/nwk_queue.sv
// Small flip-flop FIFO between lexer and checker.
`timescale 1ns / 1ps
`default_nettype none

module nwk_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_valid
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/nwk_checker_core.sv
// Back end: token order rules, parenthesis and tip counts, sticky error, result register.
`timescale 1ns / 1ps
`default_nettype none

module nwk_checker_core import nwk_pkg::*; #(
    parameter int MAX_COUNT = 4096
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_token i_token,
    input  wire logic   i_token_valid,
    output logic        o_token_take,
    input  wire logic   i_pop,
    output t_result     o_result,
    output logic        o_result_valid
);

    localparam int CW = $clog2(MAX_COUNT + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_COUNT);

    t_kind         r_prior;
    t_kind         r_first;
    logic [CW-1:0] r_depth;
    logic [CW-1:0] r_open;
    logic [CW-1:0] r_close;
    logic [CW-1:0] r_leaf;
    t_err          r_err;

    t_kind         n_prior;
    t_kind         n_first;
    logic [CW-1:0] n_depth;
    logic [CW-1:0] n_open;
    logic [CW-1:0] n_close;
    logic [CW-1:0] n_leaf;
    t_err          n_err;

    t_result r_out;
    logic    r_out_valid;

    assign o_token_take   = i_token_valid && (!r_out_valid || i_pop);
    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;

    always_comb begin
        logic  is_open;
        logic  is_close;
        logic  is_leaf;
        logic  ovf;
        t_err  cand;

        is_open  = i_token.begins && (i_token.kind == K_OPEN);
        is_close = i_token.begins && (i_token.kind == K_CLOSE);
        is_leaf  = i_token.begins && (i_token.kind == K_LABEL) &&
                   ((r_prior == K_NONE) || (r_prior == K_OPEN) || (r_prior == K_COMMA));

        n_open  = r_open;
        n_close = r_close;
        n_leaf  = r_leaf;
        n_depth = r_depth;
        ovf     = 1'b0;

        // saturating counts, overflow raised on an increment past the limit
        if (is_open) begin
            if (r_open >= MAX_C) ovf = 1'b1;
            else n_open = r_open + 1'b1;
            if (r_depth < MAX_C) n_depth = r_depth + 1'b1;
        end else if (is_close) begin
            if (r_close >= MAX_C) ovf = 1'b1;
            else n_close = r_close + 1'b1;
            if (r_depth != '0) n_depth = r_depth - 1'b1;
        end else if (is_leaf) begin
            if (r_leaf >= MAX_C) ovf = 1'b1;
            else n_leaf = r_leaf + 1'b1;
        end

        n_first = (i_token.begins && (r_first == K_NONE)) ? i_token.kind : r_first;
        n_prior = i_token.begins ? i_token.kind : r_prior;

        // stream order within one byte decides the priority
        priority if (i_token.bad_attr) begin
            cand = E_UNCLOSED;
        end else if (i_token.illegal) begin
            cand = E_ILLEGAL;
        end else if (i_token.begins && (r_first == K_NONE) && i_token.comment_start) begin
            cand = E_BLANK;
        end else if (i_token.begins && (r_first == K_NONE) &&
                     (i_token.kind != K_OPEN) && (i_token.kind != K_LABEL)) begin
            cand = E_BAD_FIRST;
        end else if ((r_first != K_NONE) && (r_first != K_OPEN) && (is_open || is_close)) begin
            cand = E_STRAY;
        end else if ((r_first == K_OPEN) && (r_depth == '0) && is_open) begin
            cand = E_SECOND;
        end else if ((r_first == K_OPEN) && (r_depth == '0) && is_close) begin
            cand = E_EXTRA;
        end else if (i_token.begins && !follow_ok(r_prior, i_token.kind)) begin
            cand = E_ORDER;
        end else if (ovf) begin
            cand = E_OVERFLOW;
        end else if (i_token.last && i_token.attr_open) begin
            cand = E_UNCLOSED;
        end else if (i_token.last && (n_first == K_NONE)) begin
            cand = E_BLANK;
        end else if (i_token.last && (n_open != n_close)) begin
            cand = E_COUNT;
        end else begin
            cand = E_OK;
        end

        n_err = (r_err != E_OK) ? r_err : cand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior <= K_NONE;
            r_first <= K_NONE;
            r_depth <= '0;
            r_open  <= '0;
            r_close <= '0;
            r_leaf  <= '0;
            r_err   <= E_OK;
        end else if (o_token_take) begin
            if (i_token.last) begin
                // clear for the next text
                r_prior <= K_NONE;
                r_first <= K_NONE;
                r_depth <= '0;
                r_open  <= '0;
                r_close <= '0;
                r_leaf  <= '0;
                r_err   <= E_OK;
            end else begin
                r_prior <= n_prior;
                r_first <= n_first;
                r_depth <= n_depth;
                r_open  <= n_open;
                r_close <= n_close;
                r_leaf  <= n_leaf;
                r_err   <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_token_take) begin
            r_out.token_kind   <= i_token.kind;
            r_out.token_begins <= i_token.begins;
            r_out.error_code   <= n_err;
            r_out.text_done    <= i_token.last;
            r_out.tips_seen    <= COUNT_OUT_W'(n_leaf);
            r_out.inner_seen   <= COUNT_OUT_W'(n_open);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_token_take) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/newick_token_validator.sv
// Top level of the Newick token validator: lexer, token queue and checker.
`timescale 1ns / 1ps
`default_nettype none

// Newick token validator. Feed the tree text one byte per transfer on the push side,
// marking the final byte with last_byte; each byte yields exactly one result on the pop
// side, in order, carrying the token kind of that byte, whether it starts a token, the
// first error seen so far in the text, and the running tip and inner node counts (low 13
// bits). The result for the last byte has text_done set and carries the final verdict;
// the block then starts over for the next text. Throughput is one byte per cycle when
// nothing stalls: the lexer classifies a byte in the cycle it is pushed, and the checker
// retires one token per cycle, while results are popped, through its single result
// register. A pushed byte passes the token queue and then that result register. The
// two-entry token queue lets the push side keep going for two bytes while the pop side
// holds off. Counts saturate at MAX_COUNT and an increment past it reports overflow.
module newick_token_validator import nwk_pkg::*; #(
    parameter int MAX_COUNT = 4096
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    push,
    output logic         full,
    input  wire t_item   i_item,
    output logic         empty,
    input  wire logic    pop,
    output t_result      o_result
);

    t_token lex_token;
    t_token q_token;
    logic   q_valid;
    logic   q_take;
    logic   push_take;
    logic   result_valid;

    // A byte transfers when the queue has room
    assign push_take = push && !full;
    assign empty     = !result_valid;

    // Front: classify each byte and advance the lexer mode
    nwk_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (push_take),
        .o_token (lex_token)
    );

    // Decouple lexer from checker so each side can stall on its own
    nwk_queue #(
        .WIDTH ($bits(t_token)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (lex_token),
        .i_rd    (q_take),
        .o_data  (q_token),
        .o_full  (full),
        .o_valid (q_valid)
    );

    // Back: apply order rules, count, hold the result until popped
    nwk_checker_core #(
        .MAX_COUNT (MAX_COUNT)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_token        (q_token),
        .i_token_valid  (q_valid),
        .o_token_take   (q_take),
        .i_pop          (pop),
        .o_result       (o_result),
        .o_result_valid (result_valid)
    );

endmodule

`default_nettype wire

>>> hw/rtl/nwk_checker.sv
// Port-level checks of the Newick token validator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module nwk_checker import nwk_pkg::*; (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    push,
    input wire logic    full,
    input wire t_item   i_item,
    input wire logic    empty,
    input wire logic    pop,
    input wire t_result o_result
);

    // Nothing waits on the result side right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // A refused byte stays on the push side until it transfers
    a_push_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && full) |=> (push && $stable(i_item)))
        else $error("refused byte dropped or changed");

    // A waiting result holds until popped
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

    // A starting byte always names its token kind
    a_begin_has_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.token_begins) |-> (o_result.token_kind != K_NONE))
        else $error("token start without kind");

    // Errors stay within one text
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_result.text_done && (o_result.error_code != E_OK))
        |=> (empty || (o_result.error_code == $past(o_result.error_code))))
        else $error("error code changed within a text");

endmodule

bind newick_token_validator nwk_checker u_nwk_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .i_item   (i_item),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

`default_nettype wire
